// ----- design/assert_macros.svh -----
// assertion helpers for the way counter checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ccwc_pkg.sv -----
`timescale 1ns / 1ps

package ccwc_pkg;

  localparam int unsigned COIN_REGS      = 6;
  localparam int unsigned MAX_COINS      = 6;
  localparam int unsigned NUM_COINS      = (MAX_COINS < COIN_REGS) ? MAX_COINS : COIN_REGS;
  localparam int unsigned DEF_MAX_AMOUNT = 255;

  localparam int unsigned COIN_W = 8;
  localparam int unsigned AMT_W  = 8;
  localparam int unsigned WAYS_W = 32;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned SEL_W  = $clog2(COIN_REGS);

  typedef logic [COIN_W-1:0] coin_t;
  typedef logic [WAYS_W:0]   entry_t;

  localparam logic [IDX_W-1:0] REG_COIN_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_COIN_A     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COIN_F     = 3'd6;

  localparam logic [CNT_W-1:0] COUNT_RESET = 3'd6;
  localparam coin_t COIN_RESET [COIN_REGS] = '{8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50};

  localparam entry_t ENTRY_ONE = {1'b0, {(WAYS_W-1){1'b0}}, 1'b1};
  localparam entry_t ENTRY_SAT = {1'b1, {WAYS_W{1'b1}}};

endpackage

// ----- design/coin_change_way_counter_unit.sv -----
`timescale 1ns / 1ps
// coin change way counter
// counts the unordered combinations of the configured coins that sum to amount
// input: start with amount, taken when busy is low; busy stays high until done
// output: done pulses for one cycle with ways and overflow; the receiver cannot stall
// config: wr_en, wr_index, wr_data write one register per cycle; the user must
//   write only while idle (not enforced by the block); index 0 coin_count,
//   indexes 1 to 6 coin_a to coin_f, other indexes ignored; one table entry is
//   updated per cycle by a single adder; table memory has 1 write, 2 read ports
// from accept to done, for an amount within the table: a clear pass over
//   entries 0 to amount, a select step per coin in use, an update pass over
//   entries coin to amount per nonzero coin not above amount, then the fetch
//   and result states
// an amount above MAX_AMOUNT gives done the cycle after accept, ways 0, overflow 1
// one transaction at a time; a new start may come in the cycle done is high
// reset returns the sequencer to idle and loads the default coin set
module coin_change_way_counter_unit
  import ccwc_pkg::*;
#(
  parameter int unsigned MAX_AMOUNT = DEF_MAX_AMOUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [AMT_W-1:0]  amount,
  output logic              done,
  output logic [WAYS_W-1:0] ways,
  output logic              overflow,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [COIN_W-1:0] wr_data
);

  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] coin_count;
  coin_t            coin [COIN_REGS];

  logic [AMT_W-1:0] amt_q;
  logic [AW-1:0]    j;
  logic [AW-1:0]    c;
  logic [CNT_W-1:0] k;

  entry_t           mem [DEPTH];
  entry_t           rd_a, rd_b;
  logic [AW-1:0]    ra_q, rb_q;
  logic             lw_vld;
  logic [AW-1:0]    lw_addr;
  entry_t           lw_data;
  logic             p_vld;
  logic [AW-1:0]    p_addr;

  logic [AW-1:0]    tgt;
  logic [CNT_W-1:0] used;
  coin_t            coin_sel;
  logic [AW-1:0]    ra, rb;
  logic             we;
  logic [AW-1:0]    wa;
  entry_t           wd;
  entry_t           a_eff, b_eff;
  logic [WAYS_W:0]  sum;
  logic             sat;
  entry_t           upd_data;
  logic             out_of_range;

  assign busy         = (state != S_IDLE);
  assign tgt          = AW'(amt_q);
  assign used         = (coin_count > CNT_W'(NUM_COINS)) ? CNT_W'(NUM_COINS) : coin_count;
  assign coin_sel     = coin[k[SEL_W-1:0]];
  assign out_of_range = (32'(amount) > MAX_AMOUNT);

  // forward the write that lands on the same edge as the read
  assign a_eff    = (lw_vld && (lw_addr == ra_q)) ? lw_data : rd_a;
  assign b_eff    = (lw_vld && (lw_addr == rb_q)) ? lw_data : rd_b;
  assign sum      = {1'b0, a_eff[WAYS_W-1:0]} + {1'b0, b_eff[WAYS_W-1:0]};
  assign sat      = a_eff[WAYS_W] | b_eff[WAYS_W] | sum[WAYS_W];
  assign upd_data = sat ? ENTRY_SAT : {1'b0, sum[WAYS_W-1:0]};

  assign ra = (state == S_FETCH) ? tgt : j;
  assign rb = j - c;

  always_comb begin
    we = 1'b0;
    wa = j;
    wd = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wd = (j == '0) ? ENTRY_ONE : '0;
    end else if (p_vld) begin
      we = 1'b1;
      wa = p_addr;
      wd = upd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a    <= mem[ra];
    rd_b    <= mem[rb];
    ra_q    <= ra;
    rb_q    <= rb;
    lw_addr <= wa;
    lw_data <= wd;
    p_addr  <= j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= COUNT_RESET;
      for (int i = 0; i < COIN_REGS; i++) begin
        coin[i] <= COIN_RESET[i];
      end
    end else if (wr_en) begin
      if (wr_index == REG_COIN_COUNT) begin
        coin_count <= wr_data[CNT_W-1:0];
      end else if (wr_index >= REG_COIN_A && wr_index <= REG_COIN_F) begin
        coin[SEL_W'(wr_index - REG_COIN_A)] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      lw_vld <= 1'b0;
      p_vld  <= 1'b0;
    end else begin
      done   <= 1'b0;
      lw_vld <= we;
      p_vld  <= (state == S_UPD);
      case (state)
        S_IDLE: begin
          if (start) begin
            if (out_of_range) begin
              ways     <= '0;
              overflow <= 1'b1;
              done     <= 1'b1;
            end else begin
              amt_q <= amount;
              j     <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (j == tgt) begin
            k     <= '0;
            state <= S_SEL;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_SEL: begin
          if (k == used) begin
            state <= S_FETCH;
          end else begin
            k <= k + 1'b1;
            if (coin_sel != '0 && coin_sel <= amt_q) begin
              c     <= AW'(coin_sel);
              j     <= AW'(coin_sel);
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (j == tgt) begin
            state <= S_SEL;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_FETCH: begin
          state <= S_RES;
        end
        S_RES: begin
          ways     <= a_eff[WAYS_W-1:0];
          overflow <= a_eff[WAYS_W];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/ccwc_check.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccwc_check
  import ccwc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [WAYS_W-1:0] ways,
  input logic              overflow
);

  // result comes out only once the transaction has finished
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "done while busy")

  // an accepted transaction either runs or answers at once
  `ASSERT_NEXT(a_accept, clk, rst, start && !busy, busy || done, "transaction dropped")

  // work only starts from an accepted transaction
  `ASSERT_IMPL(a_busy_cause, clk, rst, $rose(busy), $past(start), "busy without start")

  // a flagged count is either saturated or out of range
  `ASSERT_IMPL(a_ovf_value, clk, rst, done && overflow, ways == '0 || ways == '1,
               "overflow with a plain count")

endmodule

bind coin_change_way_counter_unit ccwc_check u_ccwc_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .ways     (ways),
  .overflow (overflow)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ccwc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 29;

  class way_scoreboard;
    bit [CNT_W-1:0]  coin_count;
    bit [COIN_W-1:0] coin_val [COIN_REGS];
    bit [WAYS_W-1:0] expected_ways [$];
    bit              expected_ovf [$];
    int unsigned     mismatches;

    function new();
      coin_count = COUNT_RESET;
      foreach (coin_val[i]) coin_val[i] = COIN_RESET[i];
      mismatches = 0;
    endfunction

    function void set_reg(bit [IDX_W-1:0] idx, bit [COIN_W-1:0] data);
      if (idx == REG_COIN_COUNT) begin
        coin_count = data[CNT_W-1:0];
      end else if (idx >= REG_COIN_A && idx <= REG_COIN_F) begin
        coin_val[idx - REG_COIN_A] = data;
      end
    endfunction

    // bottom-up table, saturating adds with a sticky mark per entry
    function void count_combinations(input bit [AMT_W-1:0] amt,
                                     output bit [WAYS_W-1:0] w, output bit ovf);
      bit [WAYS_W-1:0] tbl [DEF_MAX_AMOUNT+1];
      bit              mark [DEF_MAX_AMOUNT+1];
      bit [WAYS_W:0]   sum;
      int unsigned     used;
      int unsigned     c;
      used = (coin_count > NUM_COINS) ? NUM_COINS : 32'(coin_count);
      foreach (tbl[i]) begin
        tbl[i] = '0;
        mark[i] = 1'b0;
      end
      tbl[0] = 1;
      for (int k = 0; k < used; k++) begin
        c = 32'(coin_val[k]);
        if (c == 0) continue;
        for (int unsigned j = c; j <= amt; j++) begin
          sum = {1'b0, tbl[j]} + {1'b0, tbl[j-c]};
          if (mark[j] || mark[j-c] || sum[WAYS_W]) begin
            tbl[j] = '1;
            mark[j] = 1'b1;
          end else begin
            tbl[j] = sum[WAYS_W-1:0];
          end
        end
      end
      w = tbl[amt];
      ovf = mark[amt];
    endfunction

    function void note_query(bit [AMT_W-1:0] amt);
      bit [WAYS_W-1:0] w;
      bit              ovf;
      count_combinations(amt, w, ovf);
      expected_ways.push_back(w);
      expected_ovf.push_back(ovf);
    endfunction

    function void check_result(bit [WAYS_W-1:0] w, bit ovf);
      bit [WAYS_W-1:0] exp_w;
      bit              exp_ovf;
      if (expected_ways.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ways %0d overflow %0b", w, ovf);
        return;
      end
      exp_w = expected_ways.pop_front();
      exp_ovf = expected_ovf.pop_front();
      if (w !== exp_w || ovf !== exp_ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: ways exp %0d act %0d, overflow exp %0b act %0b",
                   exp_w, w, exp_ovf, ovf);
      end
    endfunction

    function int unsigned pending();
      return expected_ways.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [AMT_W-1:0]  amount = '0;
  logic              done;
  logic [WAYS_W-1:0] ways;
  logic              overflow;
  logic              wr_en = 1'b0;
  logic [IDX_W-1:0]  wr_index = '0;
  logic [COIN_W-1:0] wr_data = '0;

  way_scoreboard sb = new();
  int unsigned   cycles = 0;
  bit            gaps_on;

  coin_change_way_counter_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .amount(amount),
    .done(done),
    .ways(ways),
    .overflow(overflow),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("coin_change_way_counter_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(ways, overflow);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic pause(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic issue_query(bit [AMT_W-1:0] amt);
    @(negedge clk);
    start <= 1'b1;
    amount <= amt;
    do @(posedge clk); while (busy);
    sb.note_query(amt);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(bit [IDX_W-1:0] idx, bit [COIN_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_coin_set(bit [COIN_W-1:0] count_data, bit [COIN_W-1:0] c0,
                               bit [COIN_W-1:0] c1, bit [COIN_W-1:0] c2,
                               bit [COIN_W-1:0] c3, bit [COIN_W-1:0] c4,
                               bit [COIN_W-1:0] c5);
    bit [COIN_W-1:0] vals [COIN_REGS];
    vals = '{c0, c1, c2, c3, c4, c5};
    drain();
    write_reg(REG_COIN_COUNT, count_data);
    for (int i = 0; i < COIN_REGS; i++) begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        wr_en <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
      write_reg(IDX_W'(REG_COIN_A + i), vals[i]);
    end
    if ($urandom_range(0, 1)) write_reg(REG_SPARE, COIN_W'($urandom_range(0, 255)));
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic bit [COIN_W-1:0] random_coin();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 60) return COIN_W'($urandom_range(1, 12));
    return COIN_W'($urandom_range(1, 255));
  endfunction

  function automatic bit [COIN_W-1:0] random_count();
    int unsigned r;
    bit [COIN_W-1:0] v;
    r = $urandom_range(0, 9);
    // upper bits of the count register are ignored
    v = COIN_W'($urandom_range(0, 255));
    if (r == 0) v[CNT_W-1:0] = '0;
    else if (r == 1) v[CNT_W-1:0] = '1;
    else v[CNT_W-1:0] = CNT_W'($urandom_range(1, 6));
    return v;
  endfunction

  function automatic bit [AMT_W-1:0] random_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return AMT_W'($urandom_range(0, 31));
    if (r < 92) return AMT_W'($urandom_range(0, 255));
    return AMT_W'($urandom_range(224, 255));
  endfunction

  initial begin
    gaps_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coin set
    issue_query(8'd0);
    issue_query(8'd1);
    issue_query(8'd2);
    issue_query(8'd4);
    issue_query(8'd5);
    issue_query(8'd100);
    issue_query(8'd255);

    // six unit coins: saturates at the top of the table
    load_coin_set(8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    issue_query(8'd255);
    issue_query(8'd200);
    issue_query(8'd0);

    // no coins in use
    load_coin_set(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6);
    issue_query(8'd0);
    issue_query(8'd7);

    // count beyond the coin registers
    load_coin_set(8'hff, 8'd3, 8'd4, 8'd6, 8'd9, 8'd11, 8'd255);
    issue_query(8'd128);
    issue_query(8'd255);

    // zero denominations skipped
    load_coin_set(8'd6, 8'd0, 8'd2, 8'd0, 8'd3, 8'd255, 8'd1);
    issue_query(8'd50);

    // largest coins
    load_coin_set(8'd6, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    issue_query(8'd255);
    issue_query(8'd254);
    issue_query(8'd0);

    for (int p = 0; p < PHASES; p++) begin
      gaps_on = (p % 4) != 3;
      load_coin_set(random_count(), random_coin(), random_coin(), random_coin(),
                    random_coin(), random_coin(), random_coin());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pause(pick_gap());
        issue_query(random_amount());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("coin_change_way_counter_unit regression: pass");
    end else begin
      $display("coin_change_way_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ccwc_pkg.sv
design/coin_change_way_counter_unit.sv
design/ccwc_check.sv
verif/testbench.sv
